// File: design/lcnt_pkg.sv
// Package for lossy_count_ngram_table: payload and control types and constants.
// Depends on nothing.
package lcnt_pkg;

   localparam int KEY_BITS   = 63;
   localparam int CNT_BITS   = 32;
   localparam int CODE_BITS  = 21;

   localparam logic [1:0] CSR_NGRAM_LEN    = 2'd0;
   localparam logic [1:0] CSR_BUCKET_WIDTH = 2'd1;
   localparam logic [1:0] CSR_MIN_COUNT    = 2'd2;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [CODE_BITS-1:0] char_code;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] ngram_key;
      logic [CNT_BITS-1:0] count;
      logic                entry_valid;
      logic                table_overflow;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          ngram_len;
      logic [CNT_BITS-1:0] bucket_width;
      logic [CNT_BITS-1:0] min_count;
   } csr_type;

endpackage

// File: design/lossy_count_ngram_table.sv
// Lossy-counting n-gram table, top level. One entry examined per cycle.
// Character: scans the table for the key, inserts on a miss, then runs a prune scan on a
// bucket boundary; characters that do not yet fill the window leave busy low.
// End: a flush scan, at most one result per cycle; the last one comes once busy is low.
// busy high while an item is in work; results cannot be stalled.
// Synchronous reset clears control state and entry valid bits; no clearing pass.
// Depends on lcnt_pkg and lcnt_csr.
module lossy_count_ngram_table #(
   parameter int MAX_NGRAM   = 3,
   parameter int TABLE_DEPTH = 64,
   parameter int CHAR_BITS   = 21
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lcnt_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output lcnt_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [lcnt_pkg::CNT_BITS-1:0] csr_data
);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WB = MAX_NGRAM * CHAR_BITS;
   localparam logic [31:0] UMAX = 32'hFFFF_FFFF;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOOK  = 6'b000010,
      S_INS   = 6'b000100,
      S_PRUNE = 6'b001000,
      S_FLUSH = 6'b010000,
      S_CLEAR = 6'b100000
   } state_type;

   lcnt_pkg::csr_type cfg;
   lcnt_csr u_csr (.clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg);

   logic [WB-1:0] key_mem [TABLE_DEPTH];
   logic [31:0]   cnt_mem [TABLE_DEPTH];
   logic [31:0]   err_mem [TABLE_DEPTH];

   state_type state_ff, state_in;
   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   logic [WB-1:0] win_ff, win_in, key_ff, key_in;
   logic [31:0] seen_ff, seen_in, fill_ff, fill_in, bnum_ff, bnum_in;
   logic ovf_ff, ovf_in, prune_ff, prune_in, any_ff, any_in;
   logic [IW:0] idx_ff, idx_in;
   logic [IW:0] free_ff, free_in;
   logic free_ok_ff, free_ok_in;
   logic [WB-1:0] rd_key_ff;
   logic [31:0] rd_cnt_ff, rd_err_ff;
   logic rd_ok_ff, rd_ok_in;
   logic [IW-1:0] rd_idx_ff;
   logic rsp_strobe_ff, rsp_strobe_in;
   lcnt_pkg::rsp_type rsp_ff, rsp_in;
   lcnt_pkg::rsp_type hold_ff, hold_in;

   logic wr_en, hit_inc;
   logic [IW-1:0] wr_idx;
   logic [31:0] wr_cnt, wr_err;
   logic [WB-1:0] wr_key;

   logic [1:0] n_eff;
   logic [WB-1:0] nmask;
   logic [WB-1:0] shifted;
   logic [32:0] sum;
   logic [31:0] seen_nx, bw_eff;
   logic [lcnt_pkg::KEY_BITS-1:0] key_out;

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      if (cfg.ngram_len == 2'd0) n_eff = 2'd1;
      else if (32'(cfg.ngram_len) > 32'(MAX_NGRAM)) n_eff = 2'(MAX_NGRAM);
      else n_eff = cfg.ngram_len;
      nmask = '0;
      for (int c = 0; c < MAX_NGRAM; c++)
         if (c < int'(n_eff)) nmask[c*CHAR_BITS +: CHAR_BITS] = '1;
      bw_eff = (cfg.bucket_width == '0) ? 32'd1 : cfg.bucket_width;
      sum = {1'b0, rd_cnt_ff} + {1'b0, rd_err_ff};
      seen_nx = (seen_ff == UMAX) ? seen_ff : seen_ff + 32'd1;
      key_out = '0;
      key_out[WB-1:0] = rd_key_ff;
      if (WB > CHAR_BITS) shifted = (win_ff << CHAR_BITS);
      else shifted = '0;
   end

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      win_in = win_ff;
      key_in = key_ff;
      seen_in = seen_ff;
      fill_in = fill_ff;
      bnum_in = bnum_ff;
      ovf_in = ovf_ff;
      prune_in = prune_ff;
      any_in = any_ff;
      idx_in = idx_ff;
      free_in = free_ff;
      free_ok_in = free_ok_ff;
      rd_ok_in = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      hold_in = hold_ff;
      wr_en = 1'b0;
      hit_inc = 1'b0;
      wr_idx = rd_idx_ff;
      wr_key = key_ff;
      wr_cnt = 32'd1;
      wr_err = bnum_ff - 32'd1;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               if (req_data.cmd == lcnt_pkg::CMD_CHAR) begin
                  win_in = shifted | WB'(req_data.char_code[CHAR_BITS-1:0]);
                  seen_in = seen_nx;
                  if (seen_nx >= 32'(n_eff)) begin
                     key_in = win_in & nmask;
                     prune_in = (fill_ff == '0) && (seen_nx > 32'(n_eff));
                     fill_in = (fill_ff + 32'd1 >= bw_eff) ? '0 : fill_ff + 32'd1;
                     free_ok_in = 1'b0;
                     state_in = S_LOOK;
                  end
               end else begin
                  any_in = 1'b0;
                  state_in = S_FLUSH;
               end
            end
         end
         S_LOOK: begin
            if (idx_ff < (IW+1)'(TABLE_DEPTH)) begin
               idx_in = idx_ff + 1'b1;
               rd_ok_in = 1'b1;
            end
            if (rd_ok_ff) begin
               if (used_ff[rd_idx_ff] && rd_key_ff == key_ff) begin
                  hit_inc = 1'b1;
                  wr_cnt = (rd_cnt_ff == UMAX) ? rd_cnt_ff : rd_cnt_ff + 32'd1;
                  wr_err = rd_err_ff;
                  wr_key = rd_key_ff;
                  rd_ok_in = 1'b0;
                  idx_in = '0;
                  state_in = prune_ff ? S_PRUNE : S_IDLE;
               end else if (!used_ff[rd_idx_ff] && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in = (IW+1)'(rd_idx_ff);
               end
            end
            if (!hit_inc && !rd_ok_in && !rd_ok_ff) state_in = S_INS;
         end
         S_INS: begin
            if (free_ok_ff) begin
               wr_en = 1'b1;
               wr_idx = free_ff[IW-1:0];
               used_in[free_ff[IW-1:0]] = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            idx_in = '0;
            state_in = prune_ff ? S_PRUNE : S_IDLE;
         end
         S_PRUNE: begin
            if (idx_ff < (IW+1)'(TABLE_DEPTH)) begin
               idx_in = idx_ff + 1'b1;
               rd_ok_in = 1'b1;
            end
            if (rd_ok_ff && sum <= {1'b0, bnum_ff}) used_in[rd_idx_ff] = 1'b0;
            if (!rd_ok_in && !rd_ok_ff) begin
               if (bnum_ff != UMAX) bnum_in = bnum_ff + 32'd1;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (idx_ff < (IW+1)'(TABLE_DEPTH)) begin
               idx_in = idx_ff + 1'b1;
               rd_ok_in = 1'b1;
            end
            if (rd_ok_ff && used_ff[rd_idx_ff] && rd_cnt_ff >= cfg.min_count) begin
               any_in = 1'b1;
               if (any_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = hold_ff;
               end
               hold_in.ngram_key = key_out;
               hold_in.count = rd_cnt_ff;
               hold_in.entry_valid = 1'b1;
               hold_in.table_overflow = ovf_ff;
               hold_in.last = 1'b0;
            end
            if (!rd_ok_in && !rd_ok_ff) state_in = S_CLEAR;
         end
         S_CLEAR: begin
            // held entry goes out as last, or an empty marker
            rsp_strobe_in = 1'b1;
            if (any_ff) begin
               rsp_in = hold_ff;
            end else begin
               rsp_in.ngram_key = '0;
               rsp_in.count = '0;
               rsp_in.entry_valid = 1'b0;
               rsp_in.table_overflow = ovf_ff;
            end
            rsp_in.last = 1'b1;
            used_in = '0;
            win_in = '0;
            seen_in = '0;
            fill_in = '0;
            bnum_in = 32'd1;
            ovf_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (hit_inc) wr_en = 1'b1;
   end

   // flush holds each qualifying entry in hold_ff until the next one arrives, so the final one can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         win_ff <= '0;
         seen_ff <= '0;
         fill_ff <= '0;
         bnum_ff <= 32'd1;
         ovf_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         prune_ff <= 1'b0;
         any_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         win_ff <= win_in;
         seen_ff <= seen_in;
         fill_ff <= fill_in;
         bnum_ff <= bnum_in;
         ovf_ff <= ovf_in;
         rd_ok_ff <= rd_ok_in;
         rsp_strobe_ff <= rsp_strobe_in;
         prune_ff <= prune_in;
         any_ff <= any_in;
         free_ok_ff <= free_ok_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      free_ff <= free_in;
      rsp_ff <= rsp_in;
      hold_ff <= hold_in;
      rd_idx_ff <= idx_ff[IW-1:0];
      rd_key_ff <= key_mem[idx_ff[IW-1:0]];
      rd_cnt_ff <= cnt_mem[idx_ff[IW-1:0]];
      rd_err_ff <= err_mem[idx_ff[IW-1:0]];
      if (wr_en) begin
         key_mem[wr_idx] <= wr_key;
         cnt_mem[wr_idx] <= wr_cnt;
         err_mem[wr_idx] <= wr_err;
      end
   end

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy && start |=> !(state_ff == S_IDLE && $past(state_ff) == S_IDLE))
      else $error("start taken while busy");
   a_rsp_only_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_in |-> (state_ff == S_FLUSH || state_ff == S_CLEAR))
      else $error("result outside flush");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> used_ff == '0 && !ovf_ff)
      else $error("table not cleared");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> state_ff == S_IDLE)
      else $error("last result before flush end");
endmodule

// File: design/lcnt_csr.sv
// Configuration register file for lossy_count_ngram_table.
// Depends on lcnt_pkg.
module lcnt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [lcnt_pkg::CNT_BITS-1:0] csr_data,
   output lcnt_pkg::csr_type            cfg
);
   lcnt_pkg::csr_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lcnt_pkg::CSR_NGRAM_LEN:    cfg_in.ngram_len = csr_data[1:0];
            lcnt_pkg::CSR_BUCKET_WIDTH: cfg_in.bucket_width = csr_data;
            lcnt_pkg::CSR_MIN_COUNT:    cfg_in.min_count = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ngram_len    <= 2'd1;
         cfg_ff.bucket_width <= 32'd1000;
         cfg_ff.min_count    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// File: test/tb_top.sv
// Self-checking testbench for lossy_count_ngram_table: directed and random text streams
// checked against an internal lossy-counting predictor. Depends on lcnt_pkg and the RTL.
module tb_top;
   localparam int CODE_W = lcnt_pkg::CODE_BITS;

   class ngram_scoreboard;
      logic [1:0]                    ngram_len;
      logic [lcnt_pkg::CNT_BITS-1:0] bucket_width;
      logic [lcnt_pkg::CNT_BITS-1:0] min_count;
      logic [lcnt_pkg::KEY_BITS-1:0] window;
      logic [31:0]                   chars_seen;
      logic [31:0]                   bucket_fill;
      logic [31:0]                   bucket_num;
      logic [lcnt_pkg::KEY_BITS-1:0] tab_key [64];
      logic [31:0]                   tab_count [64];
      logic [31:0]                   tab_error [64];
      bit                            tab_used [64];
      bit                            overflow;
      lcnt_pkg::rsp_type             expected_rsp [$];
      int                            errors;
      int                            results_seen;
      int                            flushes;
      int                            overflow_flushes;

      function new();
         ngram_len    = 2'd1;
         bucket_width = 32'd1000;
         min_count    = 32'd0;
         errors       = 0;
         results_seen = 0;
         flushes      = 0;
         overflow_flushes = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         window      = '0;
         chars_seen  = '0;
         bucket_fill = '0;
         bucket_num  = 32'd1;
         overflow    = 1'b0;
         for (int i = 0; i < 64; i++) begin
            tab_used[i] = 1'b0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            lcnt_pkg::CSR_NGRAM_LEN:    ngram_len = val[1:0];
            lcnt_pkg::CSR_BUCKET_WIDTH: bucket_width = val;
            lcnt_pkg::CSR_MIN_COUNT:    min_count = val;
            default: ;
         endcase
      endfunction

      function void count_key(logic [lcnt_pkg::KEY_BITS-1:0] key);
         int free_idx;
         free_idx = -1;
         for (int i = 0; i < 64; i++) begin
            if (tab_used[i] && tab_key[i] == key) begin
               if (tab_count[i] != 32'hFFFF_FFFF) tab_count[i]++;
               return;
            end
            if (!tab_used[i] && free_idx < 0) free_idx = i;
         end
         if (free_idx < 0) begin
            overflow = 1'b1;
            return;
         end
         tab_used[free_idx]  = 1'b1;
         tab_key[free_idx]   = key;
         tab_count[free_idx] = 32'd1;
         tab_error[free_idx] = bucket_num - 32'd1;
      endfunction

      function void prune();
         for (int i = 0; i < 64; i++) begin
            if (tab_used[i] && ({1'b0, tab_count[i]} + {1'b0, tab_error[i]}) <= {1'b0, bucket_num})
               tab_used[i] = 1'b0;
         end
         if (bucket_num != 32'hFFFF_FFFF) bucket_num++;
      endfunction

      function void note(lcnt_pkg::req_type r);
         int n;
         logic [lcnt_pkg::KEY_BITS-1:0] key;
         lcnt_pkg::rsp_type rsp;
         int k;
         if (r.cmd == lcnt_pkg::CMD_CHAR) begin
            n = (ngram_len == 2'd0) ? 1 : int'(ngram_len);
            window = {window[lcnt_pkg::KEY_BITS-lcnt_pkg::CODE_BITS-1:0], r.char_code};
            if (chars_seen != 32'hFFFF_FFFF) chars_seen++;
            if (chars_seen < n) return;
            key = window & ((63'd1 << (n * lcnt_pkg::CODE_BITS)) - 63'd1);
            if (n == 3) key = window;
            count_key(key);
            if (bucket_fill == 0 && chars_seen > n) prune();
            bucket_fill++;
            if (bucket_fill >= bucket_width) bucket_fill = '0;
         end else begin
            k = 0;
            flushes++;
            if (overflow) overflow_flushes++;
            for (int i = 0; i < 64; i++) begin
               if (tab_used[i] && tab_count[i] >= min_count) begin
                  rsp.ngram_key      = tab_key[i];
                  rsp.count          = tab_count[i];
                  rsp.entry_valid    = 1'b1;
                  rsp.table_overflow = overflow;
                  rsp.last           = 1'b0;
                  expected_rsp.insert(expected_rsp.size(), rsp);
                  k++;
               end
            end
            if (k == 0) begin
               rsp = '0;
               rsp.table_overflow = overflow;
               rsp.last = 1'b1;
               expected_rsp.insert(expected_rsp.size(), rsp);
            end else begin
               expected_rsp[$].last = 1'b1;
            end
            clear_stream();
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= 30)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      endtask

      task check(lcnt_pkg::rsp_type got);
         lcnt_pkg::rsp_type want;
         results_seen++;
         if (expected_rsp.size() == 0) begin
            report("unexpected result", {1'b0, got.ngram_key}, '0);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.ngram_key != want.ngram_key)
            report("ngram_key", {1'b0, got.ngram_key}, {1'b0, want.ngram_key});
         if (got.count != want.count) report("count", 64'(got.count), 64'(want.count));
         if (got.entry_valid != want.entry_valid)
            report("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
         if (got.table_overflow != want.table_overflow)
            report("table_overflow", 64'(got.table_overflow), 64'(want.table_overflow));
         if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   lcnt_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   lcnt_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = lcnt_pkg::CSR_NGRAM_LEN;
   logic [31:0]       csr_data = '0;

   ngram_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int          items_sent = 0;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   lossy_count_ngram_table u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lossy_count_ngram_table: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check(rsp_data);
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   task send(logic cmd, logic [CODE_W-1:0] code, bit use_gap);
      int gap;
      gap = use_gap ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{cmd: cmd, char_code: code};
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note('{cmd: cmd, char_code: code});
      items_sent++;
   endtask

   task drain();
      start <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [31:0] val);
      repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task configure(logic [1:0] len, logic [31:0] bw, logic [31:0] mc);
      drain();
      write_csr(lcnt_pkg::CSR_NGRAM_LEN, {30'd0, len});
      write_csr(lcnt_pkg::CSR_BUCKET_WIDTH, bw);
      write_csr(lcnt_pkg::CSR_MIN_COUNT, mc);
   endtask

   initial begin
      logic [31:0] bw_pick [7] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd1000, 32'hFFFF_FFFF};
      logic [31:0] mc_pick [5] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};
      int          alpha [4] = '{2, 4, 8, 80};
      logic [CODE_W-1:0] base;
      int          span;
      int          len_items;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: code extremes, default registers, empty flush
      send(lcnt_pkg::CMD_END, '0, 1'b0);
      send(lcnt_pkg::CMD_CHAR, '0, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h1F_FFFF, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h1F_FFFF, 1'b0);
      send(lcnt_pkg::CMD_END, 21'h1F_FFFF, 1'b0);
      configure(2'd0, 32'd0, 32'd0);
      send(lcnt_pkg::CMD_CHAR, 21'h15_5555, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h0A_AAAA, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h15_5555, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h15_5555, 1'b0);
      send(lcnt_pkg::CMD_END, '0, 1'b0);
      configure(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(lcnt_pkg::CMD_CHAR, 21'h1F_FFFF, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h00_0001, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h10_0000, 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h1F_FFFF, 1'b0);
      send(lcnt_pkg::CMD_END, '0, 1'b0);
      // table full: more distinct keys than entries
      configure(2'd1, 32'd1000, 32'd1);
      for (int i = 0; i < 70; i++) send(lcnt_pkg::CMD_CHAR, CODE_W'(32'h1000 + i), 1'b0);
      send(lcnt_pkg::CMD_CHAR, 21'h1000, 1'b0);
      send(lcnt_pkg::CMD_END, '0, 1'b0);

      // random streams, mostly small alphabets so keys repeat and pruning matters
      while (items_sent < 180) begin
         configure(2'($urandom_range(0, 3)), bw_pick[$urandom_range(0, 6)],
                   mc_pick[$urandom_range(0, 4)]);
         base = CODE_W'($urandom);
         span = alpha[$urandom_range(0, 3)];
         len_items = $urandom_range(6, 40);
         for (int i = 0; i < len_items; i++) begin
            if ($urandom_range(0, 49) == 0)
               send(lcnt_pkg::CMD_END, CODE_W'($urandom), 1'b1);
            else
               send(lcnt_pkg::CMD_CHAR, base + CODE_W'($urandom_range(0, span - 1)), 1'b1);
         end
         send(lcnt_pkg::CMD_END, CODE_W'($urandom), 1'b1);
      end
      drain();

      $display("run: %0d items, %0d flushes (%0d with overflow), %0d results checked",
               items_sent, sb.flushes, sb.overflow_flushes, sb.results_seen);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("lossy_count_ngram_table: match");
      else
         $display("lossy_count_ngram_table: mismatch");
      $finish;
   end
endmodule

// File: lossy_count_ngram_table.f
design/lcnt_pkg.sv
design/lcnt_csr.sv
design/lossy_count_ngram_table.sv
test/tb_top.sv
